@@ rtl/fbne_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fbne_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;
    localparam logic [1:0] REG_OFFSET = 2'd3;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [12:0] RST_WIDTH  = 13'd768;
    localparam logic [12:0] RST_HEIGHT = 13'd512;
    localparam logic [7:0]  RST_STEP   = 8'd20;
    localparam logic [15:0] RST_OFFSET = 16'd500;

    // payload widths
    localparam int PIX_W    = 16;
    localparam int BIAS_W   = 17;
    localparam int NOISE_W  = 20;
    localparam int PCNT_W   = 24;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 80;

    // accumulator / arithmetic unit widths
    localparam int SUM_W    = 56;
    localparam int DQ_W     = 64;
    localparam int REM_W    = 24;
    localparam int SREM_W   = 34;
    localparam int ROOT_W   = 32;
    localparam int FRAC_SH  = 7;   // sum * 128 before the divide
    localparam int DIV_STEPS = 64;
    localparam int SQ_STEPS  = 32;
    localparam int CNT_W     = 7;

    typedef enum logic [3:0] {
        S_RUN,
        S_RSC,
        S_RSCW,
        S_RSR,
        S_RSRW,
        S_FOLD,
        S_LOAD,
        S_DIV,
        S_SQRT,
        S_DONE
    } fbne_state_t;

    typedef struct packed {
        logic pix_acc;
        logic rs_load;
        logic rs_sel_row;
        logic div_step;
        logic st_col;
        logic st_row;
        logic load_div;
        logic sqrt_step;
        logic done;
    } fbne_cmd_t;

    typedef struct packed {
        logic eof;
        logic cnt_zero;
        logic out_busy;
    } fbne_sts_t;

endpackage

`default_nettype wire

@@ rtl/fbne_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fbne_ctrl #(
    parameter int RS_STEPS = 12
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire                          cfg_we,
    input  wire [fbne_pkg::CFG_AW-1:0]   cfg_addr,
    input  fbne_pkg::fbne_sts_t          sts,
    output fbne_pkg::fbne_cmd_t          cmd
);

    fbne_pkg::fbne_state_t state_reg, state_next;
    logic [fbne_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic rs_pend_reg, rs_pend_next;
    logic cnt_inc;

    localparam logic [fbne_pkg::CNT_W-1:0] RS_LAST  = fbne_pkg::CNT_W'(RS_STEPS - 1);
    localparam logic [fbne_pkg::CNT_W-1:0] DIV_LAST = fbne_pkg::CNT_W'(fbne_pkg::DIV_STEPS - 1);
    localparam logic [fbne_pkg::CNT_W-1:0] SQ_LAST  = fbne_pkg::CNT_W'(fbne_pkg::SQ_STEPS - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fbne_pkg::S_RUN;
            cnt_reg     <= '0;
            rs_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rs_pend_reg <= rs_pend_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rs_pend_next = rs_pend_reg;
        cnt_inc      = 1'b0;
        cmd          = '0;
        s_tready     = 1'b0;

        unique case (state_reg)
            fbne_pkg::S_RUN: begin
                s_tready = !rs_pend_reg;
                if (rs_pend_reg) begin
                    cmd.rs_load  = 1'b1;
                    cnt_next     = '0;
                    rs_pend_next = 1'b0;
                    state_next   = fbne_pkg::S_RSC;
                end else if (s_tvalid) begin
                    cmd.pix_acc = 1'b1;
                    if (sts.eof) begin
                        state_next = fbne_pkg::S_FOLD;
                    end
                end
            end
            fbne_pkg::S_RSC: begin
                cmd.div_step = 1'b1;
                cnt_inc      = 1'b1;
                if (cnt_reg == RS_LAST) begin
                    state_next = fbne_pkg::S_RSCW;
                end
            end
            fbne_pkg::S_RSCW: begin
                cmd.st_col     = 1'b1;
                cmd.rs_load    = 1'b1;
                cmd.rs_sel_row = 1'b1;
                cnt_next       = '0;
                state_next     = fbne_pkg::S_RSR;
            end
            fbne_pkg::S_RSR: begin
                cmd.div_step = 1'b1;
                cnt_inc      = 1'b1;
                if (cnt_reg == RS_LAST) begin
                    state_next = fbne_pkg::S_RSRW;
                end
            end
            fbne_pkg::S_RSRW: begin
                cmd.st_row = 1'b1;
                state_next = fbne_pkg::S_RUN;
            end
            fbne_pkg::S_FOLD: begin
                // last square lands in the sum here; wait for the output slot
                if (!sts.out_busy) begin
                    state_next = fbne_pkg::S_LOAD;
                end
            end
            fbne_pkg::S_LOAD: begin
                cmd.load_div = 1'b1;
                cnt_next     = '0;
                state_next   = sts.cnt_zero ? fbne_pkg::S_DONE : fbne_pkg::S_DIV;
            end
            fbne_pkg::S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_inc      = 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    cnt_inc    = 1'b0;
                    cnt_next   = '0;
                    state_next = fbne_pkg::S_SQRT;
                end
            end
            fbne_pkg::S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_inc       = 1'b1;
                if (cnt_reg == SQ_LAST) begin
                    state_next = fbne_pkg::S_DONE;
                end
            end
            fbne_pkg::S_DONE: begin
                cmd.done   = 1'b1;
                state_next = fbne_pkg::S_RUN;
            end
            default: begin
                state_next = fbne_pkg::S_RUN;
            end
        endcase

        if (cnt_inc) begin
            cnt_next = cnt_reg + fbne_pkg::CNT_W'(1);
        end
        // a step write always forces a fresh phase resync
        if (cfg_we && (cfg_addr == fbne_pkg::REG_STEP)) begin
            rs_pend_next = 1'b1;
        end
    end

    a_sqrt_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fbne_pkg::S_SQRT) |-> (cnt_reg <= SQ_LAST))
        else $error("root step counter out of range");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_div |-> !sts.out_busy)
        else $error("frame result loaded while output slot busy");

endmodule

`default_nettype wire

@@ rtl/fbne_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fbne_dp #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 16,
    parameter int RS_STEPS   = 12
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  fbne_pkg::fbne_cmd_t                cmd,
    output fbne_pkg::fbne_sts_t                sts,
    input  wire                                cfg_we,
    input  wire [fbne_pkg::CFG_AW-1:0]         cfg_addr,
    input  wire [fbne_pkg::CFG_DW-1:0]         cfg_wdata,
    input  wire [fbne_pkg::PIX_W-1:0]          pixel,
    input  wire                                frame_start,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [fbne_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [0:0]                         m_tuser
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = CW + 1;
    localparam int HW  = RW + 1;
    localparam int PB  = PIXEL_BITS;
    localparam int SQW = 2 * PIXEL_BITS;
    localparam logic [PB-1:0] PIX_MASK = {PB{1'b1}};
    localparam logic [fbne_pkg::PCNT_W-1:0] PCNT_MAX = {fbne_pkg::PCNT_W{1'b1}};
    localparam logic [fbne_pkg::SUM_W-1:0]  SUM_MAX  = {fbne_pkg::SUM_W{1'b1}};

    function automatic logic [7:0] ph_inc(input logic [7:0] ph, input logic [7:0] st);
        logic [8:0] n;
        n = {1'b0, ph} + 9'd1;
        ph_inc = (n >= {1'b0, st}) ? 8'd0 : n[7:0];
    endfunction

    // configuration
    logic [12:0] width_reg, height_reg;
    logic [7:0]  step_reg;
    logic [15:0] offset_reg;

    // frame statistics
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [7:0]    colph_reg, colph_next, rowph_reg, rowph_next;
    logic [PB-1:0] min_reg, min_next, held_reg, held_next;
    logic          pend_reg, pend_next;
    logic [fbne_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [fbne_pkg::PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic [SQW-1:0] sq_reg, sq_next;
    logic           sqv_reg, sqv_next;

    // shared divide / root unit
    logic [fbne_pkg::DQ_W-1:0]   dq_reg, dq_next;
    logic [fbne_pkg::REM_W-1:0]  rem_reg, rem_next, dvs_reg, dvs_next;
    logic [fbne_pkg::SREM_W-1:0] srem_reg, srem_next;
    logic [fbne_pkg::ROOT_W-1:0] root_reg, root_next;

    // held frame result and output slot
    logic [PB-1:0]               hbg_reg, hbg_next;
    logic [fbne_pkg::PCNT_W-1:0] hcnt_reg, hcnt_next;
    logic                        hzero_reg, hzero_next;
    logic [fbne_pkg::PIX_W-1:0]   obg_reg, obg_next;
    logic [fbne_pkg::BIAS_W-1:0]  obias_reg, obias_next;
    logic [fbne_pkg::NOISE_W-1:0] onoise_reg, onoise_next;
    logic [fbne_pkg::PCNT_W-1:0]  ocnt_reg, ocnt_next;
    logic                         ozero_reg, ozero_next;
    logic                         ovalid_reg, ovalid_next;

    // combinational helpers
    logic [WW-1:0] w_eff, wm1;
    logic [HW-1:0] h_eff, hm1;
    logic [7:0]    step_eff;
    logic          clr;
    logic [CW-1:0] col_e;
    logic [RW-1:0] row_e;
    logic          pend_e;
    logic [PB-1:0] min_e, pix, diff;
    logic [fbne_pkg::PCNT_W-1:0] pcnt_e;
    logic col_end, row_end, col_on, row_on, eof;
    logic [fbne_pkg::SUM_W:0] sum_add;
    logic [RS_STEPS-1:0] pos_m1;
    logic [fbne_pkg::REM_W:0] dshift, ddiff;
    logic [fbne_pkg::SREM_W:0] sacc, strial;
    logic [fbne_pkg::PIX_W-1:0] bg16;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= fbne_pkg::RST_WIDTH;
            height_reg <= fbne_pkg::RST_HEIGHT;
            step_reg   <= fbne_pkg::RST_STEP;
            offset_reg <= fbne_pkg::RST_OFFSET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                fbne_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[12:0];
                fbne_pkg::REG_HEIGHT: height_reg <= cfg_wdata[12:0];
                fbne_pkg::REG_STEP:   step_reg   <= cfg_wdata[7:0];
                fbne_pkg::REG_OFFSET: offset_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        if (width_reg < 13'd3) begin
            w_eff = WW'(3);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg < 13'd3) begin
            h_eff = HW'(3);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
        wm1      = w_eff - WW'(1);
        hm1      = h_eff - HW'(1);
        step_eff = (step_reg == 8'd0) ? 8'd1 : step_reg;
    end

    always_comb begin
        pix    = pixel[PB-1:0];
        clr    = cmd.pix_acc && frame_start;
        col_e  = clr ? '0 : col_reg;
        row_e  = clr ? '0 : row_reg;
        pend_e = clr ? 1'b0 : pend_reg;
        min_e  = clr ? PIX_MASK : min_reg;
        pcnt_e = clr ? '0 : pcnt_reg;
        diff   = (pix >= held_reg) ? (pix - held_reg) : (held_reg - pix);

        col_end = {1'b0, col_e} >= wm1;
        row_end = {1'b0, row_e} >= hm1;
        col_on  = (col_e != '0) && ({1'b0, col_e} < wm1) && (colph_reg == 8'd0);
        row_on  = (row_e != '0) && ({1'b0, row_e} < hm1) && (rowph_reg == 8'd0);
        eof     = col_end && row_end;

        sum_add = {1'b0, sum_reg} + (fbne_pkg::SUM_W + 1)'(sq_reg);
        pos_m1  = cmd.rs_sel_row ? (RS_STEPS'(row_reg) - RS_STEPS'(1))
                                 : (RS_STEPS'(col_reg) - RS_STEPS'(1));
        dshift  = {rem_reg, dq_reg[fbne_pkg::DQ_W-1]};
        ddiff   = dshift - {1'b0, dvs_reg};
        sacc    = {srem_reg[fbne_pkg::SREM_W-2:0], dq_reg[fbne_pkg::DQ_W-1 -: 2]};
        strial  = {1'b0, root_reg, 2'b01};
        bg16    = fbne_pkg::PIX_W'(hbg_reg);
    end

    assign sts.eof      = eof;
    assign sts.cnt_zero = (pcnt_reg == '0);
    assign sts.out_busy = ovalid_reg;

    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        colph_next  = colph_reg;
        rowph_next  = rowph_reg;
        min_next    = min_reg;
        held_next   = held_reg;
        pend_next   = pend_reg;
        pcnt_next   = pcnt_reg;
        sq_next     = sq_reg;
        sqv_next    = 1'b0;
        sum_next    = sum_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        hbg_next    = hbg_reg;
        hcnt_next   = hcnt_reg;
        hzero_next  = hzero_reg;
        obg_next    = obg_reg;
        obias_next  = obias_reg;
        onoise_next = onoise_reg;
        ocnt_next   = ocnt_reg;
        ozero_next  = ozero_reg;
        ovalid_next = ovalid_reg && !m_tready;

        // squared difference is registered and added to the sum in the cycle after its pair
        if (clr) begin
            sum_next = '0;
        end else if (sqv_reg) begin
            sum_next = sum_add[fbne_pkg::SUM_W] ? SUM_MAX : sum_add[fbne_pkg::SUM_W-1:0];
        end

        if (cmd.pix_acc) begin
            col_next  = col_e;
            row_next  = row_e;
            pend_next = pend_e;
            min_next  = min_e;
            pcnt_next = pcnt_e;
            sq_next   = SQW'(diff) * SQW'(diff);
            sqv_next  = pend_e;
            if (pend_e) begin
                if (pcnt_e != PCNT_MAX) begin
                    pcnt_next = pcnt_e + fbne_pkg::PCNT_W'(1);
                end
                if (held_reg < min_e) begin
                    min_next = held_reg;
                end
                pend_next = 1'b0;
            end
            if (col_on && row_on) begin
                held_next = pix;
                pend_next = 1'b1;
            end
            if (eof) begin
                col_next  = '0;
                row_next  = '0;
                pend_next = 1'b0;
            end else if (col_end) begin
                col_next   = '0;
                row_next   = row_e + RW'(1);
                rowph_next = (row_e == '0) ? 8'd0 : ph_inc(rowph_reg, step_eff);
            end else begin
                col_next   = col_e + CW'(1);
                colph_next = (col_e == '0) ? 8'd0 : ph_inc(colph_reg, step_eff);
            end
        end

        // phase resync: (pos - 1) mod step through the divider
        if (cmd.st_col) begin
            colph_next = rem_reg[7:0];
        end
        if (cmd.st_row) begin
            rowph_next = rem_reg[7:0];
        end
        if (cmd.rs_load) begin
            dq_next  = {pos_m1, {(fbne_pkg::DQ_W - RS_STEPS){1'b0}}};
            rem_next = '0;
            dvs_next = fbne_pkg::REM_W'(step_eff);
        end

        if (cmd.load_div) begin
            dq_next    = {1'b0, sum_reg, {fbne_pkg::FRAC_SH{1'b0}}};
            rem_next   = '0;
            dvs_next   = pcnt_reg;
            srem_next  = '0;
            root_next  = '0;
            hbg_next   = min_reg;
            hcnt_next  = pcnt_reg;
            hzero_next = (pcnt_reg == '0);
            min_next   = PIX_MASK;
            pcnt_next  = '0;
            sum_next   = '0;
        end

        // restoring divide, quotient shifts into dq
        if (cmd.div_step) begin
            if (!ddiff[fbne_pkg::REM_W]) begin
                rem_next = ddiff[fbne_pkg::REM_W-1:0];
                dq_next  = {dq_reg[fbne_pkg::DQ_W-2:0], 1'b1};
            end else begin
                rem_next = dshift[fbne_pkg::REM_W-1:0];
                dq_next  = {dq_reg[fbne_pkg::DQ_W-2:0], 1'b0};
            end
        end

        // digit-by-digit root of the quotient, two bits per step
        if (cmd.sqrt_step) begin
            dq_next = {dq_reg[fbne_pkg::DQ_W-3:0], 2'b00};
            if (sacc >= strial) begin
                srem_next = fbne_pkg::SREM_W'(sacc - strial);
                root_next = {root_reg[fbne_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                srem_next = sacc[fbne_pkg::SREM_W-1:0];
                root_next = {root_reg[fbne_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        if (cmd.done) begin
            ovalid_next = 1'b1;
            ozero_next  = hzero_reg;
            if (hzero_reg) begin
                obg_next    = '0;
                obias_next  = '0;
                onoise_next = '0;
                ocnt_next   = '0;
            end else begin
                obg_next    = bg16;
                obias_next  = {1'b0, bg16} - {1'b0, offset_reg};
                onoise_next = root_reg[fbne_pkg::NOISE_W-1:0];
                ocnt_next   = hcnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            min_reg    <= PIX_MASK;
            held_reg   <= '0;
            pend_reg   <= 1'b0;
            sum_reg    <= '0;
            pcnt_reg   <= '0;
            sqv_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            min_reg    <= min_next;
            held_reg   <= held_next;
            pend_reg   <= pend_next;
            sum_reg    <= sum_next;
            pcnt_reg   <= pcnt_next;
            sqv_reg    <= sqv_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        colph_reg  <= colph_next;
        rowph_reg  <= rowph_next;
        sq_reg     <= sq_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        hbg_reg    <= hbg_next;
        hcnt_reg   <= hcnt_next;
        hzero_reg  <= hzero_next;
        obg_reg    <= obg_next;
        obias_reg  <= obias_next;
        onoise_reg <= onoise_next;
        ocnt_reg   <= ocnt_next;
        ozero_reg  <= ozero_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {3'b000, ocnt_reg, onoise_reg, obias_reg, obg_reg};
    assign m_tuser  = ozero_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.done |-> !ovalid_reg)
        else $error("result written over an untaken result");

    a_pend_col: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (col_reg != '0))
        else $error("pending pair at column zero");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ rtl/frame_background_noise_estimator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                     Payload (low bit up)
// s_ (in)   s_tvalid/s_tready         s_tdata: pixel[15:0]; s_tuser: frame_start
// m_ (out)  m_tvalid/m_tready         m_tdata: background[15:0], bias_level[32:16],
//                                     noise_dev[52:33], sample_count[76:53], pad;
//                                     m_tuser: no_samples
// cfg       cfg_we/cfg_addr/cfg_wdata 0 width, 1 height, 2 step, 3 bias offset
//
// Pixels are taken one per cycle outside the stalls below. The last pixel of a
// frame stalls s_tready through a fold, a load, 64 restoring divide steps and
// 32 root steps in the shared divide/root unit, one write-out (a frame with no
// pairs skips divide and root). A sample_step write stalls to resync the grid
// phases through the same divider. Reset is synchronous, active low, and
// needs no clearing pass. A result waits in the output register; the next frame
// streams in meanwhile, and its end holds until that result is taken.

module frame_background_noise_estimator #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [fbne_pkg::S_TDATA_W-1:0]     s_tdata,   // pixel
    input  wire [0:0]                         s_tuser,   // frame_start
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [fbne_pkg::M_TDATA_W-1:0]    m_tdata,   // background, bias_level,
                                                         // noise_dev, sample_count
    output logic [0:0]                        m_tuser,   // no_samples
    input  wire                               cfg_we,
    input  wire [fbne_pkg::CFG_AW-1:0]        cfg_addr,
    input  wire [fbne_pkg::CFG_DW-1:0]        cfg_wdata
);

    // grid phase resync divides a column or row position
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int RS_STEPS = (CW > RW) ? CW : RW;

    fbne_pkg::fbne_cmd_t cmd;
    fbne_pkg::fbne_sts_t sts;

    fbne_ctrl #(
        .RS_STEPS (RS_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .sts      (sts),
        .cmd      (cmd)
    );

    // per-pixel statistics, divide/root unit and output register
    fbne_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .RS_STEPS   (RS_STEPS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .pixel       (s_tdata),
        .frame_start (s_tuser[0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire
